/* hw/rtl/kmd_pkg.sv */
// ----------------------------------------------------------------------------
// kmd_pkg: shared types and constants for the keypad matrix debounce
// Key state codes, status codes, register indexes and the debounce
// next-state function used by every key lane.
// ----------------------------------------------------------------------------
package kmd_pkg;

	// number of key slots carried by one frame word and the handler mask
	localparam int KEY_SLOTS = 16;
	localparam int KEY_IDX_W = 4;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 16;

	typedef logic [1:0] key_state_t;
	typedef logic [1:0] status_t;
	typedef logic [KEY_IDX_W-1:0] key_idx_t;
	typedef logic [KEY_SLOTS-1:0] key_vec_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	// debounce states
	localparam key_state_t ST_RELEASED = 2'd0;
	localparam key_state_t ST_PRE_PRESSED = 2'd1;
	localparam key_state_t ST_PRESSED = 2'd2;
	localparam key_state_t ST_PRE_RELEASED = 2'd3;

	// result status codes
	localparam status_t STATUS_NONE = 2'd0;
	localparam status_t STATUS_HANDLER = 2'd1;
	localparam status_t STATUS_NO_HANDLER = 2'd2;

	// register indexes
	localparam cfg_idx_t REG_PRESSED_LEVEL = 8'd0;
	localparam cfg_idx_t REG_REPORT_STATE = 8'd1;
	localparam cfg_idx_t REG_HANDLER_MASK = 8'd2;

	// control shared by all lanes
	typedef struct packed {
		logic update;
		logic pressed_level;
		key_state_t report_state;
	} lane_ctrl_t;

	// debounce step for one key
	function automatic key_state_t next_state(key_state_t st, logic last, logic cur);
		key_state_t nxt;
		case (st)
			ST_RELEASED: nxt = (last && cur) ? ST_PRE_PRESSED : ST_RELEASED;
			ST_PRE_PRESSED: nxt = cur ? ST_PRESSED : ST_PRE_PRESSED;
			ST_PRESSED: nxt = (!last && !cur) ? ST_PRE_RELEASED : ST_PRESSED;
			default: nxt = cur ? ST_PRE_RELEASED : ST_RELEASED;
		endcase
		return nxt;
	endfunction

endpackage

/* hw/rtl/kmd_in_if.sv */
// ----------------------------------------------------------------------------
// kmd_in_if: scan frame channel
// Valid/ready channel carrying one frame of raw key levels per word.
// ----------------------------------------------------------------------------
interface kmd_in_if import kmd_pkg::*; ();
	logic valid;
	logic ready;
	key_vec_t key_levels;

	modport source (output valid, output key_levels, input ready);
	modport sink (input valid, input key_levels, output ready);
endinterface

/* hw/rtl/kmd_out_if.sv */
// ----------------------------------------------------------------------------
// kmd_out_if: report channel
// Valid/ready channel carrying the status and index of the reported key.
// ----------------------------------------------------------------------------
interface kmd_out_if import kmd_pkg::*; ();
	logic valid;
	logic ready;
	status_t status;
	key_idx_t key_index;

	modport source (output valid, output status, output key_index, input ready);
	modport sink (input valid, input status, input key_index, output ready);
endinterface

/* hw/rtl/kmd_cfg_if.sv */
// ----------------------------------------------------------------------------
// kmd_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface kmd_cfg_if import kmd_pkg::*; ();
	logic valid;
	logic ready;
	cfg_idx_t index;
	cfg_data_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/kmd_lane.sv */
// ----------------------------------------------------------------------------
// kmd_lane: debounce lane for one key
// Holds the previous sample and the debounce state of one key, advances
// them on each accepted frame and flags whether the new state is reported.
// ----------------------------------------------------------------------------
module kmd_lane import kmd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input lane_ctrl_t ctrl,
	input logic level,
	output logic match_s1
);

	logic last_q;
	key_state_t state_q;
	logic cur;
	key_state_t state_nxt;

	// decode the sample and step the debounce state
	assign cur = (level == ctrl.pressed_level);
	assign state_nxt = next_state(state_q, last_q, cur);

	// advance key state on every accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
			state_q <= ST_RELEASED;
		end else if (ctrl.update) begin
			last_q <= cur;
			state_q <= state_nxt;
		end
	end

	// hold the match flag for the merge stage
	always_ff @(posedge clk) begin
		if (ctrl.update) begin
			match_s1 <= (state_nxt == ctrl.report_state);
		end
	end

endmodule

/* hw/rtl/kmd_merge.sv */
// ----------------------------------------------------------------------------
// kmd_merge: lane merge and report register
// Picks the lowest key whose lane matched, looks up its handler bit and
// registers the status and index for the output channel.
// ----------------------------------------------------------------------------
module kmd_merge import kmd_pkg::*; (
	input logic clk,
	input logic load,
	input key_vec_t match_s1,
	input key_vec_t handler_mask,
	output status_t status_q,
	output key_idx_t key_index_q
);

	logic found;
	key_idx_t idx;

	// priority encode, lowest index wins
	always_comb begin
		found = 1'b0;
		idx = '0;
		for (int k = KEY_SLOTS - 1; k >= 0; k--) begin
			if (match_s1[k]) begin
				found = 1'b1;
				idx = KEY_IDX_W'(k);
			end
		end
	end

	// load the result word
	always_ff @(posedge clk) begin
		if (load) begin
			if (!found) begin
				status_q <= STATUS_NONE;
			end else if (handler_mask[idx]) begin
				status_q <= STATUS_HANDLER;
			end else begin
				status_q <= STATUS_NO_HANDLER;
			end
			key_index_q <= idx;
		end
	end

endmodule

/* hw/rtl/keypad_matrix_debounce.sv */
// Flow: an accepted frame word is registered in the key lanes, and the report
// register loads it from there once the output side can take a new word.
// Throughput: one frame per cycle; the key lanes and the merge register form
// a two-stage pipeline, stalled only when the report register is held.
// Reset: arst_n clears all key states to released, the previous samples to
// not pressed, the pipeline valids, and the configuration registers to their reset values.
// ----------------------------------------------------------------------------
// keypad_matrix_debounce: matrix keypad debounce and report
// One debounce lane per key updates on each frame; a merge stage reports the
// lowest key in the configured state and whether it has a handler.
// ----------------------------------------------------------------------------
module keypad_matrix_debounce import kmd_pkg::*; #(
	parameter int ROWS = 4,
	parameter int COLS = 4
) (
	input logic clk,
	input logic arst_n,
	kmd_cfg_if.sink cfg,
	kmd_in_if.sink keys,
	kmd_out_if.source result
);

	localparam int KEY_COUNT = (ROWS * COLS > KEY_SLOTS) ? KEY_SLOTS : ROWS * COLS;

	logic pressed_level_q;
	key_state_t report_state_q;
	key_vec_t handler_mask_q;
	logic valid_s1_q;
	logic out_valid_q;
	logic out_adv;
	logic in_acc;
	logic load_out;
	lane_ctrl_t lane_ctrl;
	key_vec_t match_s1;

	// configuration registers, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_level_q <= 1'b0;
			report_state_q <= ST_PRESSED;
			handler_mask_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PRESSED_LEVEL: pressed_level_q <= cfg.data[0];
				REG_REPORT_STATE: report_state_q <= cfg.data[1:0];
				REG_HANDLER_MASK: handler_mask_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// pipeline handshake
	assign out_adv = !out_valid_q || result.ready;
	assign keys.ready = !valid_s1_q || out_adv;
	assign in_acc = keys.valid && keys.ready;
	assign load_out = valid_s1_q && out_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1_q <= 1'b1;
			end else if (load_out) begin
				valid_s1_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// lanes, one per present key
	assign lane_ctrl.update = in_acc;
	assign lane_ctrl.pressed_level = pressed_level_q;
	assign lane_ctrl.report_state = report_state_q;

	for (genvar k = 0; k < KEY_SLOTS; k++) begin : g_lane
		if (k < KEY_COUNT) begin : g_key
			kmd_lane u_lane (
				.clk (clk),
				.arst_n (arst_n),
				.ctrl (lane_ctrl),
				.level (keys.key_levels[k]),
				.match_s1 (match_s1[k])
			);
		end else begin : g_absent
			assign match_s1[k] = 1'b0;
		end
	end

	// merge lanes into the result word
	kmd_merge u_merge (
		.clk (clk),
		.load (load_out),
		.match_s1 (match_s1),
		.handler_mask (handler_mask_q),
		.status_q (result.status),
		.key_index_q (result.key_index)
	);

	assign result.valid = out_valid_q;

	// input stalls only when both stages are full and the sink holds off
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!keys.ready |-> (valid_s1_q && out_valid_q && !result.ready))
		else $error("input stalled without a full pipeline");

	// an accepted frame occupies the lane stage next cycle
	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> valid_s1_q)
		else $error("accepted word lost at lane stage");

	// no-key result carries index zero
	a_none_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status == STATUS_NONE) |-> (result.key_index == '0))
		else $error("no-key result with nonzero index");

	// handler status agrees with the mask
	a_handler: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status == STATUS_HANDLER) |->
			handler_mask_q[result.key_index])
		else $error("handler status without handler bit");

	// status is never the unused code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.status == STATUS_NONE || result.status == STATUS_HANDLER
			|| result.status == STATUS_NO_HANDLER))
		else $error("invalid status code");

endmodule

/* test/tb_keypad_matrix_debounce.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keypad_matrix_debounce: self-checking bench for the keypad debouncer
// Drives scan frames through the valid/ready channels and predicts every
// report word from a per-key debounce model held in a small scoreboard.
// The model sees each frame as it is accepted and each configuration write
// as it lands. Runs a short directed sequence first, then random phases
// under several register settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_keypad_matrix_debounce;
	import kmd_pkg::*;

	localparam int ROWS = 4;
	localparam int COLS = 4;
	localparam int KEY_COUNT = (ROWS * COLS > KEY_SLOTS) ? KEY_SLOTS : ROWS * COLS;
	localparam int PHASE_WORDS = 240;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 4;
	localparam int LIMIT_CYCLES = 100000;
	localparam cfg_idx_t REG_UNUSED = 8'hff;

	typedef struct packed {
		status_t status;
		key_idx_t key_index;
	} report_t;

	// debounce predictor and queue of pending reports
	class report_scoreboard;
		bit pressed_level;
		key_state_t report_state;
		key_vec_t handler_mask;
		bit last_pressed [KEY_SLOTS];
		key_state_t key_state [KEY_SLOTS];
		report_t expected_q [$];
		int errors;

		function new();
			pressed_level = 1'b0;
			report_state = ST_PRESSED;
			handler_mask = '0;
			foreach (key_state[k]) begin
				last_pressed[k] = 1'b0;
				key_state[k] = ST_RELEASED;
			end
			errors = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, cfg_data_t data);
			case (idx)
				REG_PRESSED_LEVEL: pressed_level = data[0];
				REG_REPORT_STATE: report_state = key_state_t'(data[1:0]);
				REG_HANDLER_MASK: handler_mask = key_vec_t'(data);
				default: ;
			endcase
		endfunction

		// advance every key, then pick the lowest key in the reported state
		function void note_frame(key_vec_t levels);
			report_t rep;
			bit cur;
			bit found;
			rep.status = STATUS_NONE;
			rep.key_index = '0;
			found = 1'b0;
			for (int k = 0; k < KEY_COUNT; k++) begin
				cur = (levels[k] == pressed_level);
				case (key_state[k])
					ST_RELEASED: begin
						if (last_pressed[k] && cur)
							key_state[k] = ST_PRE_PRESSED;
					end
					ST_PRE_PRESSED: begin
						if (cur)
							key_state[k] = ST_PRESSED;
					end
					ST_PRESSED: begin
						if (!last_pressed[k] && !cur)
							key_state[k] = ST_PRE_RELEASED;
					end
					default: key_state[k] = cur ? ST_PRE_RELEASED : ST_RELEASED;
				endcase
				last_pressed[k] = cur;
			end
			for (int k = 0; k < KEY_COUNT; k++) begin
				if (!found && key_state[k] == report_state) begin
					found = 1'b1;
					rep.key_index = key_idx_t'(k);
					rep.status = handler_mask[k] ? STATUS_HANDLER : STATUS_NO_HANDLER;
				end
			end
			expected_q.push_back(rep);
		endfunction

		function void check_report(status_t status, key_idx_t key_index);
			report_t exp_rep;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected report word status=%0d key_index=%0d",
					$time, status, key_index);
				errors++;
				return;
			end
			exp_rep = expected_q.pop_front();
			if (status !== exp_rep.status) begin
				$display("%0t: status mismatch expected=%0d actual=%0d",
					$time, exp_rep.status, status);
				errors++;
			end
			if (key_index !== exp_rep.key_index) begin
				$display("%0t: key_index mismatch expected=%0d actual=%0d",
					$time, exp_rep.key_index, key_index);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit quiet;
	bit hold_req;
	bit cur_level;
	key_vec_t held_keys;
	int cycles;
	report_scoreboard sb;

	kmd_cfg_if cfg_ch ();
	kmd_in_if key_ch ();
	kmd_out_if rep_ch ();

	keypad_matrix_debounce #(
		.ROWS(ROWS),
		.COLS(COLS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.keys(key_ch),
		.result(rep_ch)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watch every handshake on the rising edge
	always @(posedge clk) begin
		if (cfg_ch.valid && cfg_ch.ready)
			sb.write_reg(cfg_ch.index, cfg_ch.data);
		if (key_ch.valid && key_ch.ready)
			sb.note_frame(key_ch.key_levels);
		if (rep_ch.valid && rep_ch.ready)
			sb.check_report(rep_ch.status, rep_ch.key_index);
	end

	// report receiver: random stalls, plus one long hold-off on request
	initial begin
		rep_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				rep_ch.ready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 99) < 8) begin
				rep_ch.ready <= 1'b0;
			end else begin
				rep_ch.ready <= 1'b1;
			end
		end
	end

	// stop a hung run
	initial begin
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// offer one frame word and hold it until accepted
	task automatic send_frame(input key_vec_t levels);
		key_ch.valid <= 1'b1;
		key_ch.key_levels <= levels;
		do @(posedge clk); while (!key_ch.ready);
	endtask

	// write one register; the caller drops valid after the last write
	task automatic program_reg(input cfg_idx_t idx, input cfg_data_t data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	// let the monitor log the last accept, wait for every pending report,
	// then let the pipeline settle
	task automatic wait_idle();
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// mostly held key patterns with occasional bounces, some pure noise
	function automatic key_vec_t next_frame();
		key_vec_t pressed;
		int k;
		if ($urandom_range(0, 99) < 15)
			return key_vec_t'($urandom());
		if ($urandom_range(0, 5) == 0) begin
			case ($urandom_range(0, 4))
				0: held_keys = key_vec_t'($urandom());
				1: held_keys = key_vec_t'($urandom() & $urandom() & $urandom());
				2: held_keys = '0;
				default: begin
					repeat ($urandom_range(1, 3)) begin
						k = $urandom_range(0, KEY_SLOTS - 1);
						held_keys[k] = ~held_keys[k];
					end
				end
			endcase
		end
		pressed = held_keys;
		if ($urandom_range(0, 9) == 0) begin
			k = $urandom_range(0, KEY_SLOTS - 1);
			pressed[k] = ~pressed[k];
		end
		return cur_level ? pressed : ~pressed;
	endfunction

	// reconfigure while idle, then stream random frames
	task automatic run_phase(input bit lvl, input key_state_t rep, input key_vec_t mask,
			input bit no_idle, input bit stall_rx, input bit pause_tx, input bit bad_reg);
		wait_idle();
		program_reg(REG_PRESSED_LEVEL, cfg_data_t'(lvl));
		program_reg(REG_REPORT_STATE, cfg_data_t'(rep));
		program_reg(REG_HANDLER_MASK, cfg_data_t'(mask));
		if (bad_reg)
			program_reg(REG_UNUSED, cfg_data_t'($urandom()));
		cfg_ch.valid <= 1'b0;
		cur_level = lvl;
		quiet = no_idle;
		for (int n = 0; n < PHASE_WORDS; n++) begin
			if (stall_rx && n == 60)
				hold_req = 1'b1;
			if (pause_tx && n == PHASE_WORDS / 2) begin
				key_ch.valid <= 1'b0;
				wait_idle();
			end
			if (!quiet) begin
				while ($urandom_range(0, 99) < 8) begin
					key_ch.valid <= 1'b0;
					@(posedge clk);
				end
			end
			send_frame(next_frame());
		end
		key_ch.valid <= 1'b0;
		quiet = 1'b0;
	endtask

	// directed frames, pressed level low: press, release, single keys,
	// pre-pressed holding through a release, alternating patterns
	key_vec_t directed [] = '{
		16'h0000, 16'h0000, 16'h0000,
		16'hffff, 16'hffff, 16'hffff,
		16'h7fff, 16'h7fff, 16'h7fff,
		16'hffff, 16'h7fff, 16'hffff, 16'hffff, 16'h7fff, 16'hffff,
		16'hfffe, 16'hfffe, 16'hffff, 16'hffff, 16'hfffe,
		16'h5aa5, 16'ha55a
	};

	initial begin
		sb = new();
		arst_n = 1'b0;
		quiet = 1'b0;
		hold_req = 1'b0;
		cur_level = 1'b0;
		held_keys = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		key_ch.valid = 1'b0;
		key_ch.key_levels = '0;

		// hold reset, then release it
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// handlers on the two end keys only
		program_reg(REG_HANDLER_MASK, 16'h8001);
		cfg_ch.valid <= 1'b0;
		foreach (directed[i])
			send_frame(directed[i]);
		key_ch.valid <= 1'b0;

		// random phases; state carries across pressed-level changes
		run_phase(1'b0, ST_PRESSED, key_vec_t'($urandom()), 1'b0, 1'b0, 1'b0, 1'b0);
		run_phase(1'b1, ST_RELEASED, 16'hffff, 1'b0, 1'b0, 1'b0, 1'b1);
		run_phase(1'b1, ST_PRE_PRESSED, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0);
		run_phase(1'b0, ST_PRE_RELEASED, key_vec_t'($urandom()), 1'b0, 1'b1, 1'b0, 1'b0);
		run_phase(1'b0, ST_PRESSED, 16'hffff, 1'b0, 1'b0, 1'b1, 1'b0);
		run_phase(1'b1, ST_PRESSED, key_vec_t'($urandom()), 1'b0, 1'b0, 1'b0, 1'b1);
		run_phase(1'b0, ST_PRE_PRESSED, key_vec_t'($urandom()), 1'b0, 1'b0, 1'b0, 1'b0);
		run_phase(1'b1, ST_PRE_RELEASED, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0);

		// drain and report
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
